// ===== design/tcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsm_pkg
// shared constants, types and helpers for the topic cosine similarity core
// ----------------------------------------------------------------------------
package tcsm_pkg;

  localparam int MaxTopics = 64;
  localparam int TopicW    = $clog2(MaxTopics);
  localparam int GramDepth = MaxTopics * (MaxTopics + 1) / 2;
  localparam int GramAw    = $clog2(GramDepth);
  localparam int GramW     = 48;
  localparam int ValW      = 16;
  localparam int TotW      = 28;
  localparam logic [GramW-1:0] GramMax = {GramW{1'b1}};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXP,
    ST_MAC_RD,
    ST_MAC_WR,
    ST_DIAG,
    ST_ROOT,
    ST_PAIR_RD,
    ST_DIV,
    ST_MEAN,
    ST_OUT
  } state_t;

  function automatic logic [16:0] exp_lut(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd62757;
      4'd2:    v = 17'd60097;
      4'd3:    v = 17'd57549;
      4'd4:    v = 17'd55109;
      4'd5:    v = 17'd52773;
      4'd6:    v = 17'd50535;
      4'd7:    v = 17'd48393;
      4'd8:    v = 17'd46341;
      4'd9:    v = 17'd44376;
      4'd10:   v = 17'd42495;
      4'd11:   v = 17'd40693;
      4'd12:   v = 17'd38968;
      4'd13:   v = 17'd37316;
      4'd14:   v = 17'd35734;
      default: v = 17'd34219;
    endcase
    return v;
  endfunction

  function automatic logic [GramAw-1:0] tri_base(input logic [TopicW-1:0] hi);
    logic [GramAw:0] h;
    h = {{(GramAw-TopicW+1){1'b0}}, hi};
    return GramAw'((h * (h + 1'b1)) >> 1);
  endfunction

endpackage

// ===== design/tcsm_ram.sv =====
// ----------------------------------------------------------------------------
// tcsm_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module tcsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/tcsm_exp.sv =====
// ----------------------------------------------------------------------------
// tcsm_exp
// multicycle fixed-point exponential, one multiply per cycle
// ----------------------------------------------------------------------------
module tcsm_exp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] log_prob,
  output logic        done,
  output logic [15:0] value
);
  import tcsm_pkg::*;

  logic [2:0]  step_r, step_nxt;
  logic [32:0] t_r, t_nxt;
  logic [31:0] a_r, a_nxt;
  logic [33:0] p_r, p_nxt;
  logic [15:0] v_r, v_nxt;
  logic [16:0] m;
  logic [5:0]  n;
  logic [49:0] prod;

  assign m    = log_prob[15] ? (17'h10000 - {1'b0, log_prob}) : 17'd0;
  assign n    = t_r[31:26];
  assign prod = 50'(exp_lut(t_r[25:22])) * 50'(p_r);

  always_comb begin
    step_nxt = step_r;
    t_nxt = t_r;
    a_nxt = a_r;
    p_nxt = p_r;
    v_nxt = v_r;
    case (step_r)
      3'd0: begin
        if (start) begin
          t_nxt = 33'(m) * 33'd94549;
          step_nxt = 3'd1;
        end
      end
      3'd1: begin
        a_nxt = 32'((29'(t_r[21:10]) * 29'd45426) >> 16);
        step_nxt = 3'd2;
      end
      3'd2: begin
        p_nxt = 34'd65536 - 34'(a_r) + 34'((a_r * a_r) >> 17);
        step_nxt = 3'd3;
      end
      3'd3: begin
        if (t_r[32:26] > 7'd16) begin
          v_nxt = '0;
        end else if ((prod >> (6'd16 + n)) > 50'd65535) begin
          v_nxt = 16'hFFFF;
        end else begin
          v_nxt = 16'(prod >> (6'd16 + n));
        end
        step_nxt = 3'd4;
      end
      default: step_nxt = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
    end else begin
      step_r <= step_nxt;
    end
    t_r <= t_nxt;
    a_r <= a_nxt;
    p_r <= p_nxt;
    v_r <= v_nxt;
  end

  assign done  = (step_r == 3'd4);
  assign value = v_r;
endmodule

// ===== design/tcsm_sqrt.sv =====
// ----------------------------------------------------------------------------
// tcsm_sqrt
// bit-pair integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module tcsm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] radicand,
  output logic        busy,
  output logic [23:0] root
);
  logic [47:0] x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    x_nxt = x_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    if (start) begin
      x_nxt = radicand;
      res_nxt = '0;
      bit_nxt = 48'h1 << 46;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= res_r + bit_r) begin
        x_nxt = x_r - (res_r + bit_r);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[23:0];
endmodule

// ===== design/tcsm_div.sv =====
// ----------------------------------------------------------------------------
// tcsm_div
// restoring divider for the cosine quotient and the mean, clamped at 1.0
// ----------------------------------------------------------------------------
module tcsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  output logic        busy,
  output logic [16:0] quot
);
  logic [63:0] q_r, q_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [48:0] trial;
  logic [47:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  assign trial = {rem_r, q_r[63]};

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 48'(trial - {1'b0, d_r});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[47:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign quot = (q_r > 64'd65536) ? 17'd65536 : q_r[16:0];
endmodule

// ===== design/topic_cosine_similarity_mean_core.sv =====
// ----------------------------------------------------------------------------
// topic_cosine_similarity_mean_core
// streamed mean pairwise cosine similarity of topic rows
// ----------------------------------------------------------------------------
// After reset the core clears its gram memory before it takes the first
// transaction. After an element at topic position p the next one can follow
// when it has been accepted, its exponential found and each buffered column
// entry up to position p multiply-accumulated; the single gram memory port
// reads and then writes each gram entry. The last element then runs K square
// roots, K(K-1)/2 divides and a mean divide, raises the result and clears the
// gram memory before the next element; a zero-norm topic skips the divides.
// No element is taken while a result transaction waits.
module topic_cosine_similarity_mean_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] in_tdata,   // log_prob
  input  logic        in_tlast,   // last_element
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic [23:0] out_tdata,  // mean_similarity[16:0], zero_norm, zero fill
  output logic        out_tvalid,
  input  logic        out_tready
);
  import tcsm_pkg::*;

  state_t state_r, state_nxt;
  logic [6:0]        ntop_r;
  logic [TopicW-1:0] kmax;
  logic [TopicW-1:0] pos_r, pos_nxt, q_r, q_nxt, i_r, i_nxt, j_r, j_nxt;
  logic              last_r, zero_r, zero_nxt, phase_r, phase_nxt;
  logic              in_acc;
  logic [15:0]       e_r, col_rd;
  logic [TopicW-1:0] col_addr, nrm_addr_j;
  logic              col_we, nrm_we;
  logic [23:0]       nrm_i, nrm_j;
  logic [TotW-1:0]   tot_r, tot_nxt;
  logic [GramAw:0]   clr_r, clr_nxt;
  logic [GramAw-1:0] gaddr;
  logic              gwe;
  logic [GramW-1:0]  gwdata, grdata;
  logic [GramW:0]    macsum;
  logic [16:0]       mean_r, mean_nxt;
  logic              ovld_r, ovld_nxt;
  logic [63:0]       dividend;
  logic [47:0]       divisor;
  logic [16:0]       quot;
  logic [23:0]       root;
  logic              exp_done;
  logic [15:0]       exp_val;
  logic [11:0]       pairs;
  logic              start_sqrt, start_div, sqrt_busy, div_busy;

  assign kmax = (ntop_r < 7'd2) ? TopicW'(1) :
                (ntop_r > 7'(MaxTopics)) ? TopicW'(MaxTopics - 1) :
                TopicW'(ntop_r - 7'd1);
  assign pairs = 12'(({6'd0, kmax} + 12'd1) * {6'd0, kmax} >> 1);

  assign in_acc     = in_tvalid && in_tready;
  assign col_we     = (state_r == ST_EXP) && exp_done;
  assign col_addr   = (state_r == ST_EXP) ? pos_r : q_r;
  assign nrm_we     = (state_r == ST_ROOT) && !sqrt_busy;
  assign nrm_addr_j = (state_r == ST_ROOT) ? i_r : j_r;

  tcsm_exp u_exp (.clk, .rst_n, .start(in_acc),
    .log_prob(in_tdata), .done(exp_done), .value(exp_val));

  tcsm_ram #(.Width(GramW), .Depth(GramDepth)) u_gram (.clk, .we(gwe),
    .addr(gaddr), .wdata(gwdata), .rdata(grdata));

  tcsm_ram #(.Width(ValW), .Depth(MaxTopics)) u_col (.clk, .we(col_we),
    .addr(col_addr), .wdata(exp_val), .rdata(col_rd));

  tcsm_ram #(.Width(24), .Depth(MaxTopics)) u_nrm_i (.clk, .we(nrm_we),
    .addr(i_r), .wdata(root), .rdata(nrm_i));

  tcsm_ram #(.Width(24), .Depth(MaxTopics)) u_nrm_j (.clk, .we(nrm_we),
    .addr(nrm_addr_j), .wdata(root), .rdata(nrm_j));

  tcsm_sqrt u_sqrt (.clk, .rst_n, .start(start_sqrt), .radicand(grdata),
    .busy(sqrt_busy), .root);

  tcsm_div u_div (.clk, .rst_n, .start(start_div), .dividend, .divisor,
    .busy(div_busy), .quot);

  assign macsum = {1'b0, grdata} + 49'(col_rd * e_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_r == (GramAw+1)'(GramDepth - 1)) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_acc) state_nxt = ST_EXP;
      ST_EXP:     if (exp_done) state_nxt = ST_MAC_RD;
      ST_MAC_RD:  state_nxt = ST_MAC_WR;
      ST_MAC_WR: begin
        if (q_r != pos_r) state_nxt = ST_MAC_RD;
        else if (last_r) state_nxt = ST_DIAG;
        else state_nxt = ST_IDLE;
      end
      ST_DIAG:    if (phase_r) state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (!sqrt_busy) begin
          if (i_r != kmax) state_nxt = ST_DIAG;
          else if (zero_r) state_nxt = ST_OUT;
          else state_nxt = ST_PAIR_RD;
        end
      end
      ST_PAIR_RD: if (phase_r) state_nxt = ST_DIV;
      ST_DIV: begin
        if (phase_r && !div_busy) begin
          state_nxt = (i_r + 1'b1 == j_r && j_r == kmax) ? ST_MEAN : ST_PAIR_RD;
        end
      end
      ST_MEAN:    if (phase_r && !div_busy) state_nxt = ST_OUT;
      ST_OUT:     if (!ovld_r) state_nxt = ST_CLEAR;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r; q_nxt = q_r; i_nxt = i_r; j_nxt = j_r;
    zero_nxt = zero_r; phase_nxt = phase_r; tot_nxt = tot_r;
    clr_nxt = clr_r; mean_nxt = mean_r; ovld_nxt = ovld_r;
    gwe = 1'b0; gaddr = GramAw'(clr_r); gwdata = '0;
    start_sqrt = 1'b0; start_div = 1'b0;
    dividend = {tot_r, 36'd0} >> 36; divisor = '0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        gwe = 1'b1;
        clr_nxt = clr_r + 1'b1;
        tot_nxt = '0; i_nxt = '0; j_nxt = '0; phase_nxt = 1'b0;
      end
      ST_IDLE: begin
        clr_nxt = '0;
        if (in_acc && pos_r > kmax) pos_nxt = '0;
        q_nxt = '0;
      end
      ST_MAC_RD: gaddr = tri_base(pos_r) + GramAw'(q_r);
      ST_MAC_WR: begin
        gaddr = tri_base(pos_r) + GramAw'(q_r);
        gwe = 1'b1;
        gwdata = macsum[GramW] ? GramMax : macsum[GramW-1:0];
        if (q_r != pos_r) begin
          q_nxt = q_r + 1'b1;
        end else begin
          pos_nxt = (pos_r >= kmax) ? '0 : pos_r + 1'b1;
          if (last_r) begin
            pos_nxt = '0;
            i_nxt = '0; phase_nxt = 1'b0; zero_nxt = 1'b0;
          end
        end
      end
      ST_DIAG: begin
        gaddr = tri_base(i_r) + GramAw'(i_r);
        phase_nxt = !phase_r;
        if (phase_r) begin
          start_sqrt = 1'b1;
          if (grdata == '0) zero_nxt = 1'b1;
        end
      end
      ST_ROOT: begin
        if (!sqrt_busy) begin
          if (i_r == kmax) begin
            i_nxt = '0; j_nxt = TopicW'(1);
            if (zero_r) mean_nxt = '0;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      ST_PAIR_RD: begin
        gaddr = tri_base(j_r) + GramAw'(i_r);
        phase_nxt = !phase_r;
        if (phase_r) begin
          start_div = 1'b1;
          dividend = {grdata, 16'd0};
          divisor = 48'(nrm_i * nrm_j);
        end
      end
      ST_DIV: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else if (!div_busy) begin
          tot_nxt = tot_r + TotW'(quot);
          phase_nxt = 1'b0;
          if (i_r + 1'b1 == j_r) begin
            i_nxt = '0; j_nxt = j_r + 1'b1;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      ST_MEAN: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
          start_div = 1'b1;
          dividend = 64'(tot_r) + 64'(pairs >> 1);
          divisor = 48'(pairs);
        end else if (!div_busy) begin
          mean_nxt = quot;
          phase_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        if (!ovld_r) begin
          ovld_nxt = 1'b1; clr_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ntop_r <= 7'd64;
      pos_r <= '0;
      clr_r <= '0;
      ovld_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= (cfg_valid && cfg_ready) ? '0 : pos_nxt;
      if (cfg_valid && cfg_ready) ntop_r <= cfg_data;
      clr_r <= clr_nxt;
      ovld_r <= ovld_nxt;
      phase_r <= phase_nxt;
    end
    q_r <= q_nxt; i_r <= i_nxt; j_r <= j_nxt;
    zero_r <= zero_nxt; tot_r <= tot_nxt; mean_r <= mean_nxt;
    if (in_acc) last_r <= in_tlast;
    if (exp_done && state_r == ST_EXP) e_r <= exp_val;
  end

  assign in_tready  = (state_r == ST_IDLE) && !ovld_r;
  assign cfg_ready  = (state_r == ST_IDLE) && !in_tvalid;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {6'd0, zero_r, zero_r ? 17'd0 : mean_r};
endmodule

// ===== design/tcsm_checker.sv =====
// ----------------------------------------------------------------------------
// tcsm_sva
// port-level checks for the cosine similarity core
// ----------------------------------------------------------------------------
module tcsm_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] <= 17'd65536)
    else $error("mean above one");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[16:0] == 17'd0)
    else $error("zero norm with nonzero mean");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
endmodule

bind topic_cosine_similarity_mean_core tcsm_sva u_chk (.*);
